### sv/dlrd_pkg.sv
// ============================================================================
// dlrd_pkg : shared types and constants for the decimal limb ring divider
// Request codes, field widths and the controller/datapath command bundle.
// ============================================================================
`default_nettype none

package dlrd_pkg;

    localparam int LIMB_W      = 30;
    localparam int PORT_PTR_W  = 11;
    localparam int SHIFT_W     = 15;
    localparam int K_W         = 4;
    localparam int KMASK_W     = 9;

    localparam logic [K_W-1:0]    FULL_PASS_BITS = 4'd9;
    localparam logic [LIMB_W-1:0] LIMB_BASE      = 30'd1000000000;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_SETPTR = 2'd1,
        REQ_DIVIDE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        RD_INDEX = 2'd0,
        RD_HIGH  = 2'd1,
        RD_NEXT  = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_INDEX = 2'd0,
        WR_PASS  = 2'd1,
        WR_PUSH  = 2'd2
    } wr_sel_t;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    set_ptrs;
        logic    pass_setup;
        logic    pass_start;
        logic    pass_step;
        logic    push;
        logic    out_load;
        logic    out_read;
    } dlrd_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic at_low;
        logic carry_nz;
    } dlrd_status_t;

endpackage

`default_nettype wire

### sv/dlrd_datapath.sv
// ============================================================================
// dlrd_datapath : limb ring, pointers and divide pass arithmetic
// One limb per cycle during a pass: registered read, shift/add, write back.
// ============================================================================
`default_nettype none

module dlrd_datapath
    import dlrd_pkg::*;
#(
    parameter int RING_DEPTH = 2048
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dlrd_cmd_t              cmd,
    output dlrd_status_t                status,
    input  wire logic [PORT_PTR_W-1:0]  index,
    input  wire logic [LIMB_W-1:0]      limb_value,
    input  wire logic [PORT_PTR_W-1:0]  low_bound,
    input  wire logic [PORT_PTR_W-1:0]  high_bound,
    input  wire logic [SHIFT_W-1:0]     shift,
    output logic [LIMB_W-1:0]           read_value,
    output logic [PORT_PTR_W-1:0]       low_index,
    output logic [PORT_PTR_W-1:0]       high_index
);

    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int MOD_STEPS = 8;

    // reduce an 11-bit position modulo the ring depth (restoring steps)
    function automatic logic [PTR_W-1:0] ring_wrap(input logic [PORT_PTR_W-1:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int j = MOD_STEPS - 1; j >= 0; j--) begin
            if (r >= (32'(RING_DEPTH) << j)) begin
                r = r - (32'(RING_DEPTH) << j);
            end
        end
        return r[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_down(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - PTR_W'(1);
    endfunction

    logic [LIMB_W-1:0]     ring_mem [RING_DEPTH];
    logic [LIMB_W-1:0]     rdata_reg;

    logic [PTR_W-1:0]      low_reg,   low_next;
    logic [PTR_W-1:0]      high_reg,  high_next;
    logic [PTR_W-1:0]      idx_reg;
    logic [LIMB_W-1:0]     limb_reg;
    logic [PTR_W-1:0]      lo_bnd_reg;
    logic [PTR_W-1:0]      hi_bnd_reg;
    logic [SHIFT_W-1:0]    rem_reg;
    logic [K_W-1:0]        k_reg;
    logic [PTR_W-1:0]      pos_reg;
    logic [LIMB_W-1:0]     carry_reg;
    logic [LIMB_W-1:0]     read_value_reg;
    logic [PORT_PTR_W-1:0] low_out_reg;
    logic [PORT_PTR_W-1:0] high_out_reg;

    logic [PTR_W-1:0]      rd_addr;
    logic [PTR_W-1:0]      wr_addr;
    logic [LIMB_W-1:0]     wr_data;
    logic [K_W-1:0]        k_pick;
    logic [KMASK_W-1:0]    kmask;
    logic [LIMB_W-1:0]     mul;
    logic [38:0]           prod;
    logic [LIMB_W:0]       sum;
    logic [LIMB_W-1:0]     pass_limb;

    // pass arithmetic
    always_comb begin
        kmask     = (KMASK_W'(1) << k_reg) - KMASK_W'(1);
        mul       = LIMB_BASE >> k_reg;
        prod      = 39'(rdata_reg[KMASK_W-1:0] & kmask) * 39'(mul);
        sum       = (LIMB_W+1)'(rdata_reg >> k_reg) + (LIMB_W+1)'(carry_reg);
        pass_limb = sum[LIMB_W-1:0];
        k_pick    = (rem_reg >= SHIFT_W'(FULL_PASS_BITS)) ? FULL_PASS_BITS
                                                           : rem_reg[K_W-1:0];
    end

    always_comb begin
        case (cmd.rd_sel)
            RD_INDEX: rd_addr = idx_reg;
            RD_HIGH:  rd_addr = high_reg;
            RD_NEXT:  rd_addr = ring_down(pos_reg);
            default:  rd_addr = idx_reg;
        endcase
        case (cmd.wr_sel)
            WR_INDEX: begin
                wr_addr = idx_reg;
                wr_data = limb_reg;
            end
            WR_PASS: begin
                wr_addr = pos_reg;
                wr_data = pass_limb;
            end
            WR_PUSH: begin
                wr_addr = ring_down(low_reg);
                wr_data = carry_reg;
            end
            default: begin
                wr_addr = idx_reg;
                wr_data = limb_reg;
            end
        endcase
    end

    // limb ring memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (cmd.set_ptrs) begin
            low_next  = lo_bnd_reg;
            high_next = hi_bnd_reg;
        end
        if (cmd.push) begin
            low_next = ring_down(low_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            low_reg  <= '0;
            high_reg <= '0;
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    // request capture, pass cursor and carry, result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req) begin
            idx_reg    <= ring_wrap(index);
            limb_reg   <= limb_value;
            lo_bnd_reg <= ring_wrap(low_bound);
            hi_bnd_reg <= ring_wrap(high_bound);
            rem_reg    <= shift;
        end
        if (cmd.pass_setup) begin
            k_reg   <= k_pick;
            rem_reg <= rem_reg - SHIFT_W'(k_pick);
        end
        if (cmd.pass_start) begin
            pos_reg   <= high_reg;
            carry_reg <= '0;
        end
        if (cmd.pass_step) begin
            carry_reg <= prod[LIMB_W-1:0];
            if (pos_reg != low_reg) begin
                pos_reg <= ring_down(pos_reg);
            end
        end
        if (cmd.out_load) begin
            read_value_reg <= cmd.out_read ? rdata_reg : '0;
            low_out_reg    <= PORT_PTR_W'(low_reg);
            high_out_reg   <= PORT_PTR_W'(high_reg);
        end
    end

    assign status.rem_zero = (rem_reg == '0);
    assign status.at_low   = (pos_reg == low_reg);
    assign status.carry_nz = (carry_reg != '0);

    assign read_value = read_value_reg;
    assign low_index  = low_out_reg;
    assign high_index = high_out_reg;

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(low_reg) < RING_DEPTH) && (32'(high_reg) < RING_DEPTH))
        else $error("ring pointer beyond ring depth");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_step |-> (k_reg != '0) && (k_reg <= FULL_PASS_BITS))
        else $error("pass width outside 1..9");

    a_carry_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_step |=> carry_reg < LIMB_BASE)
        else $error("pass carry not below the limb base");

    a_high_only_on_set: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.set_ptrs |=> $stable(high_reg))
        else $error("high pointer moved outside a set-pointers request");

endmodule

`default_nettype wire

### sv/dlrd_ctrl.sv
// ============================================================================
// dlrd_ctrl : request sequencer for the decimal limb ring divider
// Decodes each request and steps the datapath through divide passes.
// ============================================================================
`default_nettype none

module dlrd_ctrl
    import dlrd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   req_type,
    output logic              out_valid,
    input  wire logic         out_ready,
    output dlrd_cmd_t         cmd,
    input  wire dlrd_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_DIV_CHECK,
        S_PASS_START,
        S_PASS_RUN,
        S_PASS_END,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg,   req_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.rd_sel     = RD_INDEX;
        cmd.wr_sel     = WR_INDEX;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    req_next     = req_t'(req_type);
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (req_reg)
                    REQ_WRITE: begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_INDEX;
                        state_next = S_DONE;
                    end
                    REQ_SETPTR: begin
                        cmd.set_ptrs = 1'b1;
                        state_next   = S_DONE;
                    end
                    REQ_READ: begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_INDEX;
                        state_next = S_RD_WAIT;
                    end
                    REQ_DIVIDE: state_next = S_DIV_CHECK;
                    default:    state_next = S_DONE;
                endcase
            end
            S_RD_WAIT: state_next = S_DONE;
            S_DIV_CHECK: begin
                if (status.rem_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.pass_setup = 1'b1;
                    state_next     = S_PASS_START;
                end
            end
            S_PASS_START: begin
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = RD_HIGH;
                cmd.pass_start = 1'b1;
                state_next     = S_PASS_RUN;
            end
            S_PASS_RUN: begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = WR_PASS;
                cmd.pass_step = 1'b1;
                if (status.at_low) begin
                    state_next = S_PASS_END;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_PASS_END: begin
                if (status.carry_nz) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_PUSH;
                    cmd.push   = 1'b1;
                end
                state_next = S_DIV_CHECK;
            end
            S_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_read   = (req_reg == REQ_READ);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            req_reg       <= REQ_WRITE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("result overwritten while still pending");

    a_push_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> $past(state_reg == S_PASS_RUN))
        else $error("carry push not right after a pass");

    a_div_only_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_setup |-> req_reg == REQ_DIVIDE)
        else $error("divide pass started for a non-divide request");

endmodule

`default_nettype wire

### sv/decimal_limb_ring_pow2_divider.sv
// ============================================================================
// decimal_limb_ring_pow2_divider : base-1e9 limb ring with divide by 2^shift
// Top level: request sequencer plus ring datapath.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat:
//   req_type selects write limb, set pointers, divide by 2^shift or read.
//   Output channel (out_valid/out_ready) returns one beat per request:
//   read_value (zero unless a read), low_index and high_index afterwards.
//   One request is in flight at a time; in_ready is high only when the
//   sequencer is idle. A finished result sits in the output register, so
//   the next request is taken while the receiver still stalls on it; the
//   sequencer then waits before loading the following result.
//   Write and set pointers go from the execute state to the done state;
//   a read adds a wait state for the registered ring read.
//   A divide runs P = ceil(shift/9) passes, each over the N limbs in
//   the window at that pass (N grows by one per pushed carry); each pass
//   reads and rewrites one limb per cycle between its start and end states.
//   Reset clears both pointers and the output valid; ring contents are
//   undefined until written and need no clearing pass.
// ============================================================================
`default_nettype none

module decimal_limb_ring_pow2_divider
    import dlrd_pkg::*;
#(
    parameter int RING_DEPTH = 2048
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             req_type,
    input  wire logic [PORT_PTR_W-1:0]  index,
    input  wire logic [LIMB_W-1:0]      limb_value,
    input  wire logic [PORT_PTR_W-1:0]  low_bound,
    input  wire logic [PORT_PTR_W-1:0]  high_bound,
    input  wire logic [SHIFT_W-1:0]     shift,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [LIMB_W-1:0]           read_value,
    output logic [PORT_PTR_W-1:0]       low_index,
    output logic [PORT_PTR_W-1:0]       high_index
);

    dlrd_cmd_t    cmd;
    dlrd_status_t status;

    // sequencer: decode, pass loop, result handoff
    dlrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // ring memory, pointers, shift/carry arithmetic, result payload
    dlrd_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .index      (index),
        .limb_value (limb_value),
        .low_bound  (low_bound),
        .high_bound (high_bound),
        .shift      (shift),
        .read_value (read_value),
        .low_index  (low_index),
        .high_index (high_index)
    );

endmodule

`default_nettype wire
